[hdl/pdx_pkg.sv]
// shared constants, types and helper functions for the packed decimal converter
`timescale 1ns / 1ps
`default_nettype none
package pdx_pkg;

  localparam int SCRATCH_LIMBS = 128;
  localparam int LIMB_BITS     = 32;
  localparam int WORDS         = (SCRATCH_LIMBS * LIMB_BITS) / 32;
  localparam int AW            = $clog2(WORDS);
  localparam int CW            = AW + 1;
  localparam int MW            = 58;
  localparam int QW            = 66;

  localparam logic [15:0] XBIAS   = 16'd16383;
  localparam logic [14:0] XMAXEXP = 15'h7FFF;
  localparam logic [63:0] TOPBIT  = 64'h8000_0000_0000_0000;
  localparam logic [31:0] POW5_13 = 32'd1220703125;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_ZERO    = 2'd1;
  localparam logic [1:0] RM_DOWN    = 2'd2;
  localparam logic [1:0] RM_UP      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_CLASS,
    ST_DINIT,
    ST_MUL,
    ST_SCAN,
    ST_NORM,
    ST_RINIT,
    ST_DIV,
    ST_REM,
    ST_ROUND
  } pdx_state_t;

  // 5^k for k below 13
  function automatic logic [31:0] pow5_small(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd5;
      4'd2:    r = 32'd25;
      4'd3:    r = 32'd125;
      4'd4:    r = 32'd625;
      4'd5:    r = 32'd3125;
      4'd6:    r = 32'd15625;
      4'd7:    r = 32'd78125;
      4'd8:    r = 32'd390625;
      4'd9:    r = 32'd1953125;
      4'd10:   r = 32'd9765625;
      4'd11:   r = 32'd48828125;
      4'd12:   r = 32'd244140625;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  // leading zeros of a nonzero limb
  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // number of significant bits
  function automatic logic [6:0] bitlen64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // 32 bits of v starting at bit position off, zeros outside v
  function automatic logic [31:0] limb_of(input logic [63:0] v, input logic signed [13:0] off);
    logic [127:0] w;
    logic [6:0] sh;
    logic [31:0] r;
    w = {32'b0, v, 32'b0};
    sh = 7'(off + 14'sd32);
    if (off >= 14'sd64 || off <= -14'sd32) r = 32'd0;
    else r = 32'(w >> sh);
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/pdx_if.sv]
// valid/ready channel interfaces for the converter input and result beats
`timescale 1ns / 1ps
`default_nettype none
interface pdx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_high;
  logic [63:0] packed_low;
  logic [1:0]  round_mode;
  modport source (output valid, output packed_high, output packed_low, output round_mode,
                  input ready);
  modport sink (input valid, input packed_high, input packed_low, input round_mode,
                output ready);
endinterface

interface pdx_out_if;
  logic        valid;
  logic        ready;
  logic        result_sign;
  logic [14:0] result_exponent;
  logic [63:0] result_mantissa;
  logic        inexact;
  modport source (output valid, output result_sign, output result_exponent,
                  output result_mantissa, output inexact, input ready);
  modport sink (input valid, input result_sign, input result_exponent,
                input result_mantissa, input inexact, output ready);
endinterface
`default_nettype wire

[hdl/packed_decimal_to_extended_top.sv]
// packed decimal real to extended precision converter, limb-serial sequencer
//
// din carries one 96-bit packed decimal beat plus a rounding mode; dout returns
// sign, biased exponent, 64-bit mantissa and inexact. One beat is taken at a time:
// din.ready is high only while the sequencer is idle.
// Work runs on three 128 x 32-bit scratch memories with one 32x32 multiplier and one
// 33-bit subtractor; each pass walks over every limb of the scratch.
// Sequence: digit decode, one step per digit of the low word, and a classify state, then
// a setup pass, one pass per factor of 5^13 (ceil(|E-16|/13) passes, up to 130), and a
// top-down scan. Negative decimal exponents add an initial pass, 66 division passes and
// one remainder pass. Infinity, NaN and zero inputs skip the passes after classify.
// The result sits in an output register; a stalled receiver holds it, and the
// next item may be taken and worked on meanwhile, finishing only after the
// previous beat leaves.
// Synchronous reset returns the sequencer to idle and drops dout.valid; the
// scratch memory needs no clearing since every pass writes what it reads later.
`timescale 1ns / 1ps
`default_nettype none
module packed_decimal_to_extended_top (
  input  logic       clk,
  input  logic       rst,
  pdx_in_if.sink     din,
  pdx_out_if.source  dout
);
  import pdx_pkg::*;

  pdx_state_t state, state_next;

  // captured item
  logic [31:0]         hi;
  logic [63:0]         lo;
  logic [63:0]         lo_sh;
  logic [1:0]          mode;
  logic                neg;
  logic [MW-1:0]       m;
  logic signed [11:0]  dexp;
  logic [10:0]         kk;
  logic                pos;
  logic                direct;
  logic [14:0]         direct_exp;

  // sequencing
  logic [CW-1:0]       cnt;
  logic [31:0]         carry;
  logic                shin;
  logic                borrow;
  logic                cur;
  logic [6:0]          j;
  logic [QW-1:0]       q;
  logic                found;
  logic [1:0]          took;
  logic [AW-1:0]       top_limb;
  logic [95:0]         win;
  logic                sticky;
  logic [12:0]         s;
  logic                rem_or;

  // rounding inputs
  logic [63:0]         frac;
  logic                gbit;
  logic                sbit;
  logic signed [15:0]  bexp;

  // output register
  logic                ov;
  logic                o_sign;
  logic [14:0]         o_exp;
  logic [63:0]         o_mant;
  logic                o_inexact;

  // memories
  logic [31:0] dmem  [WORDS];
  logic [31:0] r0mem [WORDS];
  logic [31:0] r1mem [WORDS];
  logic [31:0] dq, r0q, r1q;
  logic [AW-1:0] d_raddr, d_waddr, r_raddr, r_waddr;
  logic          d_we, r0_we, r1_we;
  logic [31:0]   d_wdata, r0_wdata, r1_wdata;

  // datapath wires
  logic              pass_end, proc, accept, special, out_load;
  logic [AW-1:0]     rd_idx, proc_idx, scan_rd, scan_idx;
  logic [63:0]       mext, dinit_val, prod;
  logic [31:0]       mult, rq, r2;
  logic [32:0]       diff;
  logic [3:0]        mul_step;
  logic signed [14:0] jd;
  logic              nbit;
  logic signed [13:0] roff;
  logic [10:0]       mag;
  logic signed [11:0] dexp_calc;
  logic [5:0]        lz;
  logic [95:0]       shw;
  logic [12:0]       blen;
  logic [6:0]        nb;
  logic signed [15:0] dexp16;
  logic              rem_nz, rnd_inc;
  logic [64:0]       frac_inc;
  logic [15:0]       biased;

  assign accept   = din.valid && din.ready;
  assign pass_end = (cnt == CW'(WORDS));
  assign proc     = (cnt != '0);
  assign rd_idx   = cnt[AW-1:0];
  assign proc_idx = AW'(cnt - CW'(1));
  assign scan_rd  = AW'(WORDS - 1) - cnt[AW-1:0];
  assign scan_idx = AW'(CW'(WORDS) - cnt);
  assign special  = hi[30] && (hi[29:28] == 2'b11) && (hi[27:16] == 12'hFFF);
  assign mext     = {{(64 - MW){1'b0}}, m};
  assign dexp16   = {{4{dexp[11]}}, dexp};

  // exponent digits to a signed decimal exponent less sixteen
  assign mag       = 11'(hi[27:24]) * 11'd100 + 11'(hi[23:20]) * 11'd10 + 11'(hi[19:16]);
  assign dexp_calc = hi[30] ? (12'sd0 - $signed({1'b0, mag}) - 12'sd16)
                            : ($signed({1'b0, mag}) - 12'sd16);

  // shared multiplier: one limb times a power of five plus carry
  assign mul_step = (kk >= 11'd13) ? 4'd13 : kk[3:0];
  assign mult     = (kk >= 11'd13) ? POW5_13 : pow5_small(kk[3:0]);
  assign prod     = dq * mult + {32'b0, carry};
  assign dinit_val = pos ? mext : 64'd1;

  // shared subtractor: doubled remainder limb minus divisor limb
  assign rq   = cur ? r1q : r0q;
  assign r2   = {rq[30:0], shin};
  assign diff = {1'b0, r2} - {1'b0, dq} - {32'b0, borrow};

  // dividend bit entering the remainder on this division step
  assign jd   = $signed({8'b0, j}) - $signed({2'b0, s});
  assign nbit = (!jd[14] && jd < 15'sd64) ? mext[jd[5:0]] : 1'b0;
  assign roff = $signed(14'({rd_idx, 5'b0}) + 14'd66 - 14'(s));

  // normalization of the top window found by the scan
  assign lz   = clz32(win[95:64]);
  assign shw  = win << lz;
  assign blen = 13'({top_limb, 5'b0}) + 13'd32 - {7'b0, lz};
  assign nb   = bitlen64(mext);
  assign rem_nz = rem_or || (rq != 32'd0);

  // rounding decision
  always_comb begin
    case (mode)
      RM_NEAREST: rnd_inc = gbit && (sbit || frac[0]);
      RM_ZERO:    rnd_inc = 1'b0;
      RM_DOWN:    rnd_inc = neg && (gbit || sbit);
      RM_UP:      rnd_inc = !neg && (gbit || sbit);
      default:    rnd_inc = 1'b0;
    endcase
  end
  assign frac_inc = {1'b0, frac} + 65'd1;
  assign biased   = XBIAS + bexp;
  assign out_load = (state == ST_ROUND) && (!ov || dout.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (din.valid) state_next = ST_DIGITS;
      ST_DIGITS: if (cnt == CW'(15)) state_next = ST_CLASS;
      ST_CLASS: begin
        if (special || m == '0) state_next = ST_ROUND;
        else state_next = ST_DINIT;
      end
      ST_DINIT:  if (pass_end) state_next = (kk != '0) ? ST_MUL : ST_SCAN;
      ST_MUL:    if (pass_end && kk == 11'(mul_step)) state_next = ST_SCAN;
      ST_SCAN:   if (pass_end) state_next = ST_NORM;
      ST_NORM:   state_next = pos ? ST_ROUND : ST_RINIT;
      ST_RINIT:  if (pass_end) state_next = ST_DIV;
      ST_DIV:    if (pass_end && j == 7'd0) state_next = ST_REM;
      ST_REM:    if (pass_end) state_next = ST_ROUND;
      ST_ROUND:  if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    d_raddr  = (state == ST_SCAN) ? scan_rd : rd_idx;
    r_raddr  = rd_idx;
    d_we     = 1'b0;
    d_waddr  = rd_idx;
    d_wdata  = 32'd0;
    r0_we    = 1'b0;
    r1_we    = 1'b0;
    r_waddr  = rd_idx;
    r0_wdata = 32'd0;
    r1_wdata = 32'd0;
    case (state)
      ST_DINIT: begin
        d_we = !pass_end;
        if (rd_idx == AW'(0)) d_wdata = dinit_val[31:0];
        else if (rd_idx == AW'(1)) d_wdata = dinit_val[63:32];
        else d_wdata = 32'd0;
      end
      ST_MUL: begin
        d_we    = proc;
        d_waddr = proc_idx;
        d_wdata = prod[31:0];
      end
      ST_RINIT: begin
        r0_we    = !pass_end;
        r0_wdata = limb_of(mext, roff);
      end
      ST_DIV: begin
        r0_we    = proc;
        r1_we    = proc;
        r_waddr  = proc_idx;
        r0_wdata = cur ? diff[31:0] : r2;
        r1_wdata = cur ? r2 : diff[31:0];
      end
      default: begin
        d_we = 1'b0;
      end
    endcase
  end

  // scratch memories
  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    dq <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (r0_we) r0mem[r_waddr] <= r0_wdata;
    r0q <= r0mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (r1_we) r1mem[r_waddr] <= r1_wdata;
    r1q <= r1mem[r_raddr];
  end

  // state and pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state || pass_end || state == ST_IDLE || state == ST_ROUND)
        cnt <= '0;
      else
        cnt <= cnt + CW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          hi    <= din.packed_high;
          lo    <= din.packed_low;
          lo_sh <= din.packed_low;
          mode  <= din.round_mode;
          neg   <= din.packed_high[31];
          m     <= MW'(din.packed_high[3:0]);
        end
      end
      ST_DIGITS: begin
        m     <= (m << 3) + (m << 1) + MW'(lo_sh[63:60]);
        lo_sh <= lo_sh << 4;
      end
      ST_CLASS: begin
        direct <= special || (m == '0);
        gbit   <= 1'b0;
        sbit   <= 1'b0;
        bexp   <= 16'sd0;
        dexp   <= dexp_calc;
        pos    <= !dexp_calc[11];
        kk     <= dexp_calc[11] ? 11'(12'sd0 - dexp_calc) : 11'(dexp_calc);
        if (special) begin
          direct_exp <= XMAXEXP;
          frac       <= (lo == 64'd0) ? TOPBIT : lo;
        end else begin
          direct_exp <= 15'd0;
          frac       <= 64'd0;
        end
      end
      ST_MUL: begin
        if (!proc) carry <= 32'd0;
        else carry <= prod[63:32];
        if (pass_end) kk <= kk - 11'(mul_step);
      end
      ST_SCAN: begin
        if (!proc) begin
          found    <= 1'b0;
          took     <= 2'd0;
          sticky   <= 1'b0;
          win      <= '0;
          top_limb <= '0;
        end else if (!found) begin
          if (dq != 32'd0) begin
            found    <= 1'b1;
            took     <= 2'd1;
            top_limb <= scan_idx;
            win      <= {dq, 64'b0};
          end
        end else if (took == 2'd1) begin
          win[63:32] <= dq;
          took       <= 2'd2;
        end else if (took == 2'd2) begin
          win[31:0] <= dq;
          took      <= 2'd3;
        end else begin
          sticky <= sticky || (dq != 32'd0);
        end
      end
      ST_NORM: begin
        if (pos) begin
          frac <= shw[95:32];
          gbit <= shw[31];
          sbit <= sticky || (shw[30:0] != 31'd0);
          bexp <= $signed({3'b0, blen}) - 16'sd1 + dexp16;
        end else begin
          s <= 13'd65 + blen - {6'b0, nb};
        end
      end
      ST_RINIT: begin
        cur <= 1'b0;
        j   <= 7'(QW - 1);
        q   <= '0;
      end
      ST_DIV: begin
        if (!proc) begin
          shin   <= nbit;
          borrow <= 1'b0;
        end else if (!pass_end) begin
          shin   <= rq[31];
          borrow <= diff[32];
        end else begin
          q <= {q[QW-2:0], !diff[32]};
          if (!diff[32]) cur <= !cur;
          j <= j - 7'd1;
        end
      end
      ST_REM: begin
        if (!proc) rem_or <= 1'b0;
        else rem_or <= rem_or || (rq != 32'd0);
        if (pass_end) begin
          if (q[QW-1]) begin
            frac <= q[QW-1:2];
            gbit <= q[1];
            sbit <= rem_nz || q[0];
            bexp <= 16'sd65 - $signed({3'b0, s}) + dexp16;
          end else begin
            frac <= q[QW-2:1];
            gbit <= q[0];
            sbit <= rem_nz;
            bexp <= 16'sd64 - $signed({3'b0, s}) + dexp16;
          end
        end
      end
      default: begin
        carry <= carry;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
    end else if (dout.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_sign    <= neg;
      o_inexact <= gbit || sbit;
      if (direct) begin
        o_exp  <= direct_exp;
        o_mant <= frac;
      end else if (rnd_inc && frac_inc[64]) begin
        o_exp  <= biased[14:0] + 15'd1;
        o_mant <= TOPBIT;
      end else begin
        o_exp  <= biased[14:0];
        o_mant <= rnd_inc ? frac_inc[63:0] : frac;
      end
    end
  end

  assign din.ready            = (state == ST_IDLE);
  assign dout.valid           = ov;
  assign dout.result_sign     = o_sign;
  assign dout.result_exponent = o_exp;
  assign dout.result_mantissa = o_mant;
  assign dout.inexact         = o_inexact;

`ifndef SYNTH
  // pass counter never runs past one extra pipeline slot
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(WORDS))
    else $error("pass counter out of range");

  // an accepted beat starts digit decode and closes the input
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_DIGITS) && !din.ready)
    else $error("accepted beat did not start decode");

  // division step index stays within the quotient width
  a_div_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (j <= 7'(QW - 1)))
    else $error("division step out of range");

  // both remainder banks are written only by a division pass
  a_dual_write: assert property (@(posedge clk) disable iff (rst)
    (r0_we && r1_we) |-> (state == ST_DIV))
    else $error("dual bank write outside division");

  // a result waiting downstream is never replaced
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ov && !dout.ready) |-> !out_load)
    else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire
